>>> hdl/ppd_pkg.sv
`default_nettype none
package ppd_pkg;

  localparam int CHANNEL_COUNT_DEFAULT = 8;

  localparam int TIME_W  = 32;
  localparam int WIDTH_W = 16;
  localparam int VALUE_W = 17;
  localparam int SEL_W   = 3;
  localparam int CFG_W   = 16;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // stream payload layout
  localparam int S_TDATA_W   = 40;
  localparam int S_TUSER_W   = 1;
  localparam int S_TIME_LSB  = 0;
  localparam int S_SEL_LSB   = S_TIME_LSB + TIME_W;
  localparam int S_MID_BIT   = S_SEL_LSB + SEL_W;
  localparam int M_TDATA_W   = 40;

  localparam logic [1:0] REG_STOP_TRIGGER  = 2'd0;
  localparam logic [1:0] REG_START_TRIGGER = 2'd1;
  localparam logic [1:0] REG_DEAD_BAND     = 2'd2;

  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [CFG_W-1:0] STOP_TRIGGER_RESET  = 16'd3000;
  localparam logic [CFG_W-1:0] START_TRIGGER_RESET = 16'd300;
  localparam logic [CFG_W-1:0] DEAD_BAND_RESET     = 16'd0;

  localparam logic [WIDTH_W-1:0] BASE_OFFSET_US = 16'd600;
  localparam logic [WIDTH_W-1:0] MID_OFFSET_US  = 16'd500;

  typedef struct packed {
    logic [CFG_W-1:0] stop_trigger_us;
    logic [CFG_W-1:0] start_trigger_us;
    logic [CFG_W-1:0] dead_band;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] edge_time_us;
    logic [SEL_W-1:0]  channel_index;
    logic              use_mid;
  } item_t;

endpackage
`default_nettype wire

>>> hdl/ppd_apb_regs.sv
`default_nettype none
module ppd_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppd_pkg::PADDR_W-1:0] paddr,
  input  logic [ppd_pkg::PDATA_W-1:0] pwdata,
  output logic [ppd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output ppd_pkg::cfg_t               cfg
);
  import ppd_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_trigger_us  <= STOP_TRIGGER_RESET;
      cfg.start_trigger_us <= START_TRIGGER_RESET;
      cfg.dead_band        <= DEAD_BAND_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_STOP_TRIGGER:  cfg.stop_trigger_us  <= pwdata[CFG_W-1:0];
        REG_START_TRIGGER: cfg.start_trigger_us <= pwdata[CFG_W-1:0];
        REG_DEAD_BAND:     cfg.dead_band        <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_STOP_TRIGGER:  prdata = PDATA_W'(cfg.stop_trigger_us);
      REG_START_TRIGGER: prdata = PDATA_W'(cfg.start_trigger_us);
      REG_DEAD_BAND:     prdata = PDATA_W'(cfg.dead_band);
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/ppd_edge_tracker.sv
`default_nettype none
module ppd_edge_tracker #(
  parameter int CHANNEL_COUNT = ppd_pkg::CHANNEL_COUNT_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ppd_pkg::cfg_t               cfg,
  input  logic                        edge_en,
  input  logic [ppd_pkg::TIME_W-1:0]  edge_time_us,
  input  logic [ppd_pkg::SEL_W-1:0]   rd_channel,
  output logic [ppd_pkg::WIDTH_W-1:0] rd_width
);
  import ppd_pkg::*;

  localparam int CH_W  = $clog2(CHANNEL_COUNT + 1);
  localparam int CMP_W = (CH_W > SEL_W) ? CH_W : SEL_W;

  logic [TIME_W-1:0]  last_edge_time;
  logic [TIME_W-1:0]  gap;
  logic [CH_W-1:0]    current_channel;
  logic [CH_W-1:0]    current_channel_next;
  logic [WIDTH_W-1:0] channel_widths [CHANNEL_COUNT];
  logic               over_stop;
  logic               over_start;
  logic               in_range;
  logic               capture;

  // wraps modulo 2^32 with the timestamp
  assign gap        = edge_time_us - last_edge_time;
  assign over_stop  = gap > TIME_W'(cfg.stop_trigger_us);
  assign over_start = gap > TIME_W'(cfg.start_trigger_us);
  assign in_range   = current_channel < CH_W'(CHANNEL_COUNT);
  assign capture    = edge_en && !over_stop && over_start && in_range;

  always_comb begin
    current_channel_next = current_channel;
    if (edge_en && over_stop) begin
      current_channel_next = '0;
    end else if (capture) begin
      current_channel_next = current_channel + CH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time  <= '0;
      current_channel <= '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        channel_widths[i] <= '0;
      end
    end else begin
      if (edge_en) begin
        last_edge_time <= edge_time_us;
      end
      current_channel <= current_channel_next;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        if (capture && current_channel == CH_W'(i)) begin
          // at or below the stop threshold, so it fits in 16 bits
          channel_widths[i] <= gap[WIDTH_W-1:0];
        end
      end
    end
  end

  // channels past the end read as zero
  always_comb begin
    rd_width = '0;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      if (CMP_W'(rd_channel) == CMP_W'(i)) begin
        rd_width = channel_widths[i];
      end
    end
  end

  a_channel_bound: assert property (@(posedge clk) disable iff (rst)
    current_channel <= CH_W'(CHANNEL_COUNT))
    else $error("channel index past saturation");

  a_long_gap_restart: assert property (@(posedge clk) disable iff (rst)
    (edge_en && over_stop) |=> current_channel == '0)
    else $error("long gap did not restart the frame");

  a_capture_advance: assert property (@(posedge clk) disable iff (rst)
    capture |=> current_channel == $past(current_channel) + CH_W'(1))
    else $error("capture did not advance the channel");

endmodule
`default_nettype wire

>>> hdl/ppd_scale.sv
`default_nettype none
module ppd_scale (
  input  logic [ppd_pkg::WIDTH_W-1:0]        raw_width,
  input  logic                               use_mid,
  input  logic [ppd_pkg::CFG_W-1:0]          dead_band,
  output logic signed [ppd_pkg::VALUE_W-1:0] channel_value
);
  import ppd_pkg::*;

  localparam int EXT_W = VALUE_W + 1;

  logic signed [EXT_W-1:0] width_s;
  logic signed [EXT_W-1:0] offset;
  logic signed [EXT_W-1:0] diff;
  logic signed [EXT_W-1:0] db_pos;
  logic signed [EXT_W-1:0] db_neg;

  assign width_s = $signed(EXT_W'(raw_width));
  assign offset  = use_mid ? $signed(EXT_W'(BASE_OFFSET_US) + EXT_W'(MID_OFFSET_US))
                           : $signed(EXT_W'(BASE_OFFSET_US));
  assign diff    = width_s - offset;
  assign db_pos  = $signed(EXT_W'(dead_band));
  assign db_neg  = -db_pos;

  always_comb begin
    if (raw_width == '0) begin
      // never captured
      channel_value = '0;
    end else if (diff < db_pos && diff > db_neg) begin
      channel_value = '0;
    end else begin
      channel_value = diff[VALUE_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> hdl/ppm_pulse_train_decoder.sv
// ppm pulse train decoder
// slave stream (s_*) takes one item per transaction: tuser is func (0 edge
// event, 1 channel read); tdata carries edge_time_us, channel_index, use_mid.
// master stream (m_*) returns one result per read and none per edge event:
// tdata carries the scaled channel_value and the raw captured width.
// thresholds and deadband sit in three 16-bit registers on the apb port
// (stop trigger at 0x0, start trigger at 0x4, deadband at 0x8); write them
// only while no transaction is in flight.
// an accepted item is registered in the input stage and decoded there; a
// read's result then goes to the result register, which drives m_tvalid.
// throughput: one item per cycle unless a read waits on a full result
// register; each item uses the single decode stage, fed by the input register.
// when the receiver stalls, the result register holds; edge events keep
// flowing behind it, and a read waits in the input stage, which then
// deasserts s_tready until the result register frees.
// reset clears the thresholds to their defaults (3000, 300, 0), the last edge
// time and channel index to zero, and every captured width to zero.
`default_nettype none
module ppm_pulse_train_decoder #(
  parameter int CHANNEL_COUNT = ppd_pkg::CHANNEL_COUNT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // apb configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppd_pkg::PADDR_W-1:0]   paddr,
  input  logic [ppd_pkg::PDATA_W-1:0]   pwdata,
  output logic [ppd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [31:0] edge_time_us, [34:32] channel_index, [35] use_mid, [39:36] zero
  input  logic [ppd_pkg::S_TDATA_W-1:0] s_tdata,
  // [0] func
  input  logic [ppd_pkg::S_TUSER_W-1:0] s_tuser,
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [16:0] channel_value, [32:17] raw_width_us, [39:33] zero
  output logic [ppd_pkg::M_TDATA_W-1:0] m_tdata
);
  import ppd_pkg::*;

  cfg_t                       cfg;
  item_t                      in_item;
  item_t                      s1_item;
  logic                       s1_valid;
  logic                       s1_fire;
  logic                       out_free;
  logic                       out_load;
  logic                       edge_en;
  logic [WIDTH_W-1:0]         rd_width;
  logic signed [VALUE_W-1:0]  scaled_value;
  logic                       out_valid;
  logic signed [VALUE_W-1:0]  out_value;
  logic [WIDTH_W-1:0]         out_raw;

  ppd_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_item.func          = s_tuser[0];
  assign in_item.edge_time_us  = s_tdata[S_TIME_LSB +: TIME_W];
  assign in_item.channel_index = s_tdata[S_SEL_LSB +: SEL_W];
  assign in_item.use_mid       = s_tdata[S_MID_BIT];

  // edge events never need the result register
  assign out_free = !out_valid || m_tready;
  assign s1_fire  = s1_valid && (s1_item.func == FUNC_EDGE || out_free);
  assign s_tready = !s1_valid || s1_fire;
  assign edge_en  = s1_fire && s1_item.func == FUNC_EDGE;
  assign out_load = s1_fire && s1_item.func == FUNC_READ;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item <= in_item;
    end
  end

  ppd_edge_tracker #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_tracker (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .edge_en      (edge_en),
    .edge_time_us (s1_item.edge_time_us),
    .rd_channel   (s1_item.channel_index),
    .rd_width     (rd_width)
  );

  ppd_scale u_scale (
    .raw_width     (rd_width),
    .use_mid       (s1_item.use_mid),
    .dead_band     (cfg.dead_band),
    .channel_value (scaled_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= scaled_value;
      out_raw   <= rd_width;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_TDATA_W - WIDTH_W - VALUE_W){1'b0}}, out_raw, out_value};

  a_edge_no_result: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_item.func == FUNC_EDGE && out_free) |=> !m_tvalid)
    else $error("edge event produced a result");

  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_item.func == FUNC_READ && out_free) |=> m_tvalid)
    else $error("read did not reach the result register");

  a_uncaptured_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_raw == '0) |-> out_value == '0)
    else $error("uncaptured channel gave a nonzero value");

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ppd_pkg::*;

  localparam int NUM_CH      = CHANNEL_COUNT_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 4;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [WIDTH_W-1:0]        raw;
  } reading_t;

  typedef struct {
    logic              func;
    logic [TIME_W-1:0] t;
    logic [SEL_W-1:0]  ch;
    logic              mid;
    bit                typed;
    logic signed [VALUE_W-1:0] value;
    logic [WIDTH_W-1:0]        raw;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // [31:0] edge_time_us, [34:32] channel_index, [35] use_mid, [39:36] zero
  logic [S_TDATA_W-1:0] s_tdata = '0;
  // [0] func
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // [16:0] channel_value, [32:17] raw_width_us, [39:33] zero
  logic [M_TDATA_W-1:0] m_tdata;

  ppm_pulse_train_decoder dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // decoder copy: thresholds, frame position and captured widths
  logic [CFG_W-1:0]   cfg_stop = STOP_TRIGGER_RESET;
  logic [CFG_W-1:0]   cfg_start = START_TRIGGER_RESET;
  logic [CFG_W-1:0]   cfg_db = DEAD_BAND_RESET;
  logic [TIME_W-1:0]  edge_last = '0;
  logic [3:0]         chan_pos = '0;
  logic [WIDTH_W-1:0] widths [NUM_CH];

  reading_t expected_reads [$];
  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_pending = 1'b0;
  int  hold_left = 0;
  dir_row_t dir_rows [23];

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // one accepted item through the decoder copy
  task automatic decode_item(input logic func, input logic [TIME_W-1:0] t,
                             input logic [SEL_W-1:0] ch, input logic mid,
                             output bit is_read, output reading_t r);
    logic [TIME_W-1:0] gap;
    int w;
    int v;
    int db;
    gap = t - edge_last;
    is_read = 1'b0;
    r = '0;
    if (func == FUNC_EDGE) begin
      edge_last = t;
      if (gap > TIME_W'(cfg_stop)) begin
        chan_pos = '0;
      end else if (gap > TIME_W'(cfg_start)) begin
        if (chan_pos < NUM_CH) begin
          widths[chan_pos[2:0]] = gap[WIDTH_W-1:0];
          chan_pos = chan_pos + 4'd1;
        end
      end
    end else begin
      is_read = 1'b1;
      w = int'(widths[ch]);
      v = 0;
      db = int'(cfg_db);
      if (w != 0) begin
        v = w - int'(BASE_OFFSET_US);
        if (mid) v = v - int'(MID_OFFSET_US);
        if (v < db && v > -db) v = 0;
      end
      r.value = v[VALUE_W-1:0];
      r.raw = w[WIDTH_W-1:0];
    end
  endtask

  task automatic offer_item(input logic func, input logic [TIME_W-1:0] t,
                            input logic [SEL_W-1:0] ch, input logic mid,
                            input bit typed = 1'b0, input reading_t typed_r = '0);
    int n;
    bit is_read;
    reading_t r;
    n = 0;
    if (!quiet) begin
      while ($urandom_range(99) < 36) n++;
    end
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {4'b0, mid, ch, t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_item(func, t, ch, mid, is_read, r);
    if (is_read) expected_reads.push_back(typed ? typed_r : r);
  endtask

  task automatic send_gap(input logic [TIME_W-1:0] gap);
    offer_item(FUNC_EDGE, edge_last + gap, SEL_W'($urandom), 1'($urandom));
  endtask

  task automatic send_read();
    offer_item(FUNC_READ, $urandom, SEL_W'($urandom), 1'($urandom));
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_STOP_TRIGGER: cfg_stop = val;
      REG_START_TRIGGER: cfg_start = val;
      REG_DEAD_BAND: cfg_db = val;
      default: ;
    endcase
  endtask

  task automatic write_setting(input logic [CFG_W-1:0] stop_us,
                               input logic [CFG_W-1:0] start_us,
                               input logic [CFG_W-1:0] db);
    s_tvalid <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    // an edge event may still sit in the pipe with no result behind it
    repeat (SETTLE) @(posedge clk);
    apb_write(REG_STOP_TRIGGER, stop_us);
    apb_write(REG_START_TRIGGER, start_us);
    apb_write(REG_DEAD_BAND, db);
  endtask

  // mostly well-formed frames: sync gap, channel gaps with some noise, then reads
  task automatic run_random(input int n_items);
    int done;
    int k;
    int sel;
    logic [TIME_W-1:0] gap;
    done = 0;
    while (done < n_items) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        if ($urandom_range(99) < 15) gap = $urandom;
        else gap = TIME_W'(cfg_stop) + 1 + $urandom_range(30000);
        send_gap(gap);
        done++;
        k = $urandom_range(10, 1);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(99) < 15) begin
            send_gap($urandom_range(int'(cfg_start), 0));
            done++;
          end
          if (cfg_start < cfg_stop) begin
            gap = $urandom_range(int'(cfg_stop), int'(cfg_start) + 1);
          end else begin
            gap = $urandom_range(65535);
          end
          send_gap(gap);
          done++;
        end
        k = $urandom_range(4, 1);
        for (int i = 0; i < k; i++) send_read();
        done += k;
      end else if (sel < 85) begin
        k = $urandom_range(6, 1);
        for (int i = 0; i < k; i++) send_read();
        done += k;
      end else begin
        // absolute jumps across the whole time range
        offer_item(FUNC_EDGE, $urandom, SEL_W'($urandom), 1'($urandom));
        done++;
      end
    end
  endtask

  // result side: random stalls, one long hold-off on request, and the checker
  always @(posedge clk) begin
    reading_t want;
    logic signed [VALUE_W-1:0] got_value;
    logic [WIDTH_W-1:0] got_raw;
    if (!rst && m_tvalid && m_tready) begin
      got_value = m_tdata[VALUE_W-1:0];
      got_raw = m_tdata[VALUE_W+WIDTH_W-1:VALUE_W];
      if (expected_reads.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d raw %0d",
                                  got_value, got_raw));
      end else begin
        want = expected_reads.pop_front();
        if (got_value !== want.value)
          report_mismatch($sformatf("channel_value %0d, want %0d", got_value, want.value));
        if (got_raw !== want.raw)
          report_mismatch($sformatf("raw_width_us %0d, want %0d", got_raw, want.raw));
      end
    end
    if (quiet) begin
      m_tready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= 36);
    end
  end

  initial begin
    int drain;
    for (int i = 0; i < NUM_CH; i++) widths[i] = '0;
    dir_rows = '{
      // reads straight after reset see no captured width
      '{FUNC_READ, 32'd0, 3'd0, 1'b0, 1'b1, 17'sd0, 16'd0},
      '{FUNC_READ, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1, 17'sd0, 16'd0},
      '{FUNC_EDGE, 32'd3001, 3'd0, 1'b0, 1'b0, 17'sd0, 16'd0},
      '{FUNC_EDGE, 32'd3301, 3'd0, 1'b0, 1'b0, 17'sd0, 16'd0},
      '{FUNC_EDGE, 32'd3602, 3'd0, 1'b0, 1'b0, 17'sd0, 16'd0},
      '{FUNC_EDGE, 32'd6602, 3'd0, 1'b0, 1'b0, 17'sd0, 16'd0},
      '{FUNC_EDGE, 32'd8102, 3'd0, 1'b0, 1'b0, 17'sd0, 16'd0},
      '{FUNC_EDGE, 32'd8702, 3'd0, 1'b0, 1'b0, 17'sd0, 16'd0},
      '{FUNC_EDGE, 32'd9802, 3'd0, 1'b0, 1'b0, 17'sd0, 16'd0},
      '{FUNC_EDGE, 32'd10802, 3'd0, 1'b0, 1'b0, 17'sd0, 16'd0},
      '{FUNC_EDGE, 32'd11802, 3'd0, 1'b0, 1'b0, 17'sd0, 16'd0},
      '{FUNC_EDGE, 32'd12802, 3'd0, 1'b0, 1'b0, 17'sd0, 16'd0},
      // ninth channel gap in a frame of eight is dropped
      '{FUNC_EDGE, 32'd14802, 3'd0, 1'b0, 1'b0, 17'sd0, 16'd0},
      '{FUNC_READ, 32'd0, 3'd0, 1'b0, 1'b1, -17'sd299, 16'd301},
      '{FUNC_READ, 32'd0, 3'd1, 1'b1, 1'b0, 17'sd0, 16'd0},
      '{FUNC_READ, 32'd0, 3'd3, 1'b0, 1'b1, 17'sd0, 16'd600},
      '{FUNC_READ, 32'd0, 3'd4, 1'b1, 1'b1, 17'sd0, 16'd1100},
      '{FUNC_READ, 32'd0, 3'd7, 1'b1, 1'b0, 17'sd0, 16'd0},
      // timestamp wrap: a short gap across 2^32
      '{FUNC_EDGE, 32'hFFFF_FF00, 3'd7, 1'b1, 1'b0, 17'sd0, 16'd0},
      '{FUNC_EDGE, 32'h0000_0100, 3'd0, 1'b0, 1'b0, 17'sd0, 16'd0},
      '{FUNC_READ, 32'd0, 3'd0, 1'b1, 1'b0, 17'sd0, 16'd0},
      '{FUNC_EDGE, 32'h0000_00FF, 3'd0, 1'b0, 1'b0, 17'sd0, 16'd0},
      '{FUNC_READ, 32'd0, 3'd2, 1'b0, 1'b0, 17'sd0, 16'd0}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      offer_item(dir_rows[i].func, dir_rows[i].t, dir_rows[i].ch, dir_rows[i].mid,
                 dir_rows[i].typed, '{dir_rows[i].value, dir_rows[i].raw});
    end
    run_random(80);

    write_setting(16'hFFFF, 16'd0, 16'd0);
    quiet = 1'b1;
    run_random(100);
    quiet = 1'b0;

    write_setting(16'd2500, 16'd900, 16'd200);
    hold_pending = 1'b1;
    run_random(100);

    write_setting(16'd0, 16'd0, 16'hFFFF);
    run_random(80);

    // start above stop: nothing is ever captured
    write_setting(16'd1000, 16'd2000, 16'd50);
    run_random(80);

    write_setting(16'hFFFF, 16'hFFFF, 16'd1);
    run_random(80);

    write_setting(CFG_W'($urandom_range(6000, 1000)), CFG_W'($urandom_range(1000)),
                  CFG_W'($urandom_range(1500)));
    run_random(150);

    s_tvalid <= 1'b0;
    drain = 0;
    while (expected_reads.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (expected_reads.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_reads.size()));
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
